/* src/tlbc_pkg.sv */
// Shared constants, codes and types of the TLB request coalescer.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package tlbc_pkg;

  // Sizing
  localparam int NUM_GROUPS  = 16;
  localparam int MAX_MEMBERS = 8;
  localparam int PAGE_SHIFT  = 12;
  localparam int MAX_PROBES  = 8;
  localparam int RES_MAX     = 8;
  localparam int MEMBER_CAP  = (MAX_MEMBERS < RES_MAX) ? MAX_MEMBERS : RES_MAX;
  localparam int PROBE_CAP   = (MAX_PROBES < RES_MAX) ? MAX_PROBES : RES_MAX;

  // Field widths
  localparam int ID_W    = 8;
  localparam int VA_W    = 48;
  localparam int PA_W    = 52;
  localparam int TIME_W  = 40;
  localparam int WT_W    = 16;
  localparam int PROBE_W = 4;
  localparam int CRED_W  = 4;
  localparam int SHIFT_W = 5;
  localparam int HIT_W   = 2;
  localparam int PAGE_W  = VA_W - PAGE_SHIFT;

  // Internal widths
  localparam int GIDX_W  = $clog2(NUM_GROUPS);
  localparam int RANK_W  = $clog2(NUM_GROUPS + 1);
  localparam int CNT_W   = $clog2(MEMBER_CAP + 1);
  localparam int MADDR_W = $clog2(NUM_GROUPS * MEMBER_CAP);
  localparam int MDATA_W = ID_W + VA_W;

  // Input modes
  localparam logic [1:0] MODE_REQ   = 2'd0;
  localparam logic [1:0] MODE_PROBE = 2'd1;
  localparam logic [1:0] MODE_RESP  = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_SEND   = 2'd0;
  localparam logic [1:0] KIND_REPLY  = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_WINDOW   = 2'd0;
  localparam logic [1:0] CFG_COALESCE = 2'd1;
  localparam logic [1:0] CFG_PROBES   = 2'd2;

  typedef enum logic [1:0] {
    ST_FREE,
    ST_WAIT,
    ST_FLIGHT
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_REQ_SCAN,
    S_REQ_DO,
    S_PR_WIN,
    S_PR_RANK,
    S_PR_FLT,
    S_PR_RD,
    S_PR_EMIT,
    S_RSP_SCAN,
    S_RSP_RD,
    S_RSP_EMIT,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [WT_W-1:0]    window_ticks;
    logic               coalesce_off;
    logic [PROBE_W-1:0] probes_per_cycle;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [ID_W-1:0]  id;
    logic [PA_W-1:0]  addr;
    logic             wr;
    logic             unc;
    logic [HIT_W-1:0] hit;
    logic             last;
  } res_t;

  // Member store address of member k of group slot
  function automatic logic [MADDR_W-1:0] maddr(input logic [GIDX_W-1:0] slot,
                                               input logic [CNT_W-1:0] k);
    logic [MADDR_W-1:0] base;
    base = MADDR_W'(slot) * MADDR_W'(MEMBER_CAP);
    return base + MADDR_W'(k);
  endfunction

endpackage

/* src/tlb_request_coalescer.sv */
// Top level of the TLB request coalescer: configuration registers, divider,
// member store and sequencer. Depends on tlbc_pkg, tlbc_div, tlbc_mem, tlbc_ctrl.
`timescale 1ns / 1ps

// The block takes one item at a time and holds in_stall_o high until the
// item's last result is in the output register. A request runs the
// bit-serial window divide, scans the group table, then writes. A probe
// tick scans the table once per window and, for each group it visits,
// twice more (rank lookup and in-flight page check), and reads the first
// member of each group it sends. A response scans the table to find its
// group, then reads and emits one reply per member. The single table
// scan pointer and the member store's single read port set this order.
// Results wait in the output register while the next one is prepared.

module tlb_request_coalescer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [tlbc_pkg::WT_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    mode_i,
  input  logic [tlbc_pkg::ID_W-1:0]     req_id_i,
  input  logic [tlbc_pkg::VA_W-1:0]     vaddr_i,
  input  logic                          is_write_i,
  input  logic [tlbc_pkg::TIME_W-1:0]   issue_time_i,
  input  logic [tlbc_pkg::CRED_W-1:0]   down_credits_i,
  input  logic [tlbc_pkg::PA_W-1:0]     resp_paddr_i,
  input  logic [tlbc_pkg::SHIFT_W-1:0]  resp_page_shift_i,
  input  logic                          resp_uncacheable_i,
  input  logic [tlbc_pkg::HIT_W-1:0]    resp_hit_level_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    kind_o,
  output logic [tlbc_pkg::ID_W-1:0]     out_id_o,
  output logic [tlbc_pkg::PA_W-1:0]     out_addr_o,
  output logic                          out_write_o,
  output logic                          out_uncacheable_o,
  output logic [tlbc_pkg::HIT_W-1:0]    out_hit_level_o,
  output logic                          last_o
);
  import tlbc_pkg::*;

  cfg_t               cfg_q;
  logic [WT_W-1:0]    divisor;
  logic               div_start, div_done;
  logic [TIME_W-1:0]  div_quot;
  logic               mem_we;
  logic [MADDR_W-1:0] mem_waddr, mem_raddr;
  logic [MDATA_W-1:0] mem_wdata, mem_rdata;
  res_t               res;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_ticks     <= WT_W'(1);
      cfg_q.coalesce_off     <= 1'b0;
      cfg_q.probes_per_cycle <= PROBE_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WINDOW:   cfg_q.window_ticks     <= cfg_data_i;
        CFG_COALESCE: cfg_q.coalesce_off     <= cfg_data_i[0];
        CFG_PROBES:   cfg_q.probes_per_cycle <= cfg_data_i[PROBE_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero window acts as one tick
  assign divisor = (cfg_q.window_ticks == '0) ? WT_W'(1) : cfg_q.window_ticks;

  tlbc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (issue_time_i),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  tlbc_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  tlbc_ctrl u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .mode_i             (mode_i),
    .req_id_i           (req_id_i),
    .vaddr_i            (vaddr_i),
    .is_write_i         (is_write_i),
    .down_credits_i     (down_credits_i),
    .resp_paddr_i       (resp_paddr_i),
    .resp_page_shift_i  (resp_page_shift_i),
    .resp_uncacheable_i (resp_uncacheable_i),
    .resp_hit_level_i   (resp_hit_level_i),
    .div_start_o        (div_start),
    .div_done_i         (div_done),
    .div_quot_i         (div_quot),
    .mem_we_o           (mem_we),
    .mem_waddr_o        (mem_waddr),
    .mem_wdata_o        (mem_wdata),
    .mem_raddr_o        (mem_raddr),
    .mem_rdata_i        (mem_rdata),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_o              (res)
  );

  assign kind_o            = res.kind;
  assign out_id_o          = res.id;
  assign out_addr_o        = res.addr;
  assign out_write_o       = res.wr;
  assign out_uncacheable_o = res.unc;
  assign out_hit_level_o   = res.hit;
  assign last_o            = res.last;

endmodule

/* src/tlbc_div.sv */
// Restoring divider, one quotient bit per cycle: issue time over window length.
// Depends on tlbc_pkg.
`timescale 1ns / 1ps

module tlbc_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [tlbc_pkg::TIME_W-1:0] dividend_i,
  input  logic [tlbc_pkg::WT_W-1:0]   divisor_i,
  output logic                       done_o,
  output logic [tlbc_pkg::TIME_W-1:0] quot_o
);
  import tlbc_pkg::*;

  localparam int DCNT_W = $clog2(TIME_W + 1);

  logic              busy_q;
  logic              done_q;
  logic [DCNT_W-1:0] cnt_q;
  logic [TIME_W-1:0] quo_q;
  logic [WT_W-1:0]   rem_q;
  logic [WT_W-1:0]   div_q;
  logic [WT_W:0]     rem_sh;
  logic              ge;
  logic [WT_W:0]     rem_n;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    rem_sh = {rem_q, quo_q[TIME_W-1]};
    ge     = rem_sh >= {1'b0, div_q};
    rem_n  = ge ? (rem_sh - {1'b0, div_q}) : rem_sh;
  end

  // Step control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DCNT_W'(TIME_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DCNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_n[WT_W-1:0];
      quo_q <= {quo_q[TIME_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

/* src/tlbc_mem.sv */
// Member store: tag and virtual address of every group member, one write
// and one registered read port. Depends on tlbc_pkg.
`timescale 1ns / 1ps

module tlbc_mem (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [tlbc_pkg::MADDR_W-1:0] waddr_i,
  input  logic [tlbc_pkg::MDATA_W-1:0] wdata_i,
  input  logic [tlbc_pkg::MADDR_W-1:0] raddr_i,
  output logic [tlbc_pkg::MDATA_W-1:0] rdata_o
);
  import tlbc_pkg::*;

  logic [MDATA_W-1:0] mem_q [NUM_GROUPS*MEMBER_CAP];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* src/tlbc_ctrl.sv */
// Sequencer of the coalescer: group table, table scans one slot per cycle,
// result hold and output register. Depends on tlbc_pkg.
`timescale 1ns / 1ps

module tlbc_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tlbc_pkg::cfg_t                cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    mode_i,
  input  logic [tlbc_pkg::ID_W-1:0]     req_id_i,
  input  logic [tlbc_pkg::VA_W-1:0]     vaddr_i,
  input  logic                          is_write_i,
  input  logic [tlbc_pkg::CRED_W-1:0]   down_credits_i,
  input  logic [tlbc_pkg::PA_W-1:0]     resp_paddr_i,
  input  logic [tlbc_pkg::SHIFT_W-1:0]  resp_page_shift_i,
  input  logic                          resp_uncacheable_i,
  input  logic [tlbc_pkg::HIT_W-1:0]    resp_hit_level_i,
  output logic                          div_start_o,
  input  logic                          div_done_i,
  input  logic [tlbc_pkg::TIME_W-1:0]   div_quot_i,
  output logic                          mem_we_o,
  output logic [tlbc_pkg::MADDR_W-1:0]  mem_waddr_o,
  output logic [tlbc_pkg::MDATA_W-1:0]  mem_wdata_o,
  output logic [tlbc_pkg::MADDR_W-1:0]  mem_raddr_o,
  input  logic [tlbc_pkg::MDATA_W-1:0]  mem_rdata_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output tlbc_pkg::res_t                out_o
);
  import tlbc_pkg::*;

  // Group table
  status_e           status_q [NUM_GROUPS];
  logic [CNT_W-1:0]  cnt_q    [NUM_GROUPS];
  logic [PAGE_W-1:0] page_q   [NUM_GROUPS];
  logic              wr_q     [NUM_GROUPS];
  logic [TIME_W-1:0] win_q    [NUM_GROUPS];
  logic [GIDX_W-1:0] age_q    [NUM_GROUPS];

  state_e state_q, state_d;
  logic [GIDX_W-1:0] idx_q;

  // Captured item
  logic [ID_W-1:0]    r_id_q;
  logic [VA_W-1:0]    r_va_q;
  logic               r_wr_q;
  logic [PA_W-1:0]    r_pa_q;
  logic [SHIFT_W-1:0] r_shift_q;
  logic               r_unc_q;
  logic [HIT_W-1:0]   r_hit_q;
  logic [PAGE_W-1:0]  r_page;

  // Request scan
  logic              best_v_q, slot_v_q;
  logic [GIDX_W-1:0] best_q, best_age_q, slot_q;
  logic [CNT_W-1:0]  best_cnt_q;
  logic [RANK_W-1:0] rank_q;

  // Probe and response walk
  logic               found_q, busy_q, refused_q, have_prev_q;
  logic [CRED_W-1:0]  cred_q;
  logic [PROBE_W-1:0] limit_q, n_q, lim;
  logic [RANK_W-1:0]  r_q;
  logic [CNT_W-1:0]   k_q, sel_cnt_q;
  logic [TIME_W-1:0]  w_q, prev_q;
  logic [GIDX_W-1:0]  sel_q;
  logic [PAGE_W-1:0]  sel_page_q;
  logic               sel_wr_q;

  // Result hold and output register
  res_t hold_q, out_q, new_res;
  logic hold_v_q, out_v_q;

  // Control strobes
  logic accept, scan_end, out_free, emit_go, push_out, last_member;

  // Entry under the scan pointer
  status_e           e_st;
  logic [PAGE_W-1:0] e_page;
  logic              e_wr;
  logic [TIME_W-1:0] e_win;
  logic [GIDX_W-1:0] e_age;
  logic [CNT_W-1:0]  e_cnt;
  logic join_hit, free_hit, rank_inc, win_hit, rank_hit, flt_hit, rsp_hit;
  logic [PA_W-1:0] mask, va_ext, reply_addr;

  assign r_page = r_va_q[VA_W-1:PAGE_SHIFT];

  // Per-slot compares at the scan pointer
  always_comb begin
    e_st   = status_q[idx_q];
    e_page = page_q[idx_q];
    e_wr   = wr_q[idx_q];
    e_win  = win_q[idx_q];
    e_age  = age_q[idx_q];
    e_cnt  = cnt_q[idx_q];
    join_hit = !cfg_i.coalesce_off && e_st == ST_WAIT && e_win == div_quot_i &&
               e_page == r_page && e_wr == r_wr_q && e_cnt < CNT_W'(MEMBER_CAP) &&
               (!best_v_q || e_age < best_age_q);
    free_hit = e_st == ST_FREE && !slot_v_q;
    rank_inc = e_st == ST_WAIT && e_win == div_quot_i;
    win_hit  = e_st == ST_WAIT && (!have_prev_q || e_win > prev_q) &&
               (!found_q || e_win < w_q);
    rank_hit = e_st == ST_WAIT && e_win == w_q && RANK_W'(e_age) == r_q;
    flt_hit  = e_st == ST_FLIGHT && e_page == sel_page_q;
    rsp_hit  = !found_q && e_st == ST_FLIGHT && e_page == r_page;
  end

  // Probe limit from the register
  always_comb begin
    if (cfg_i.probes_per_cycle == '0) begin
      lim = PROBE_W'(1);
    end else if (cfg_i.probes_per_cycle > PROBE_W'(PROBE_CAP)) begin
      lim = PROBE_W'(PROBE_CAP);
    end else begin
      lim = cfg_i.probes_per_cycle;
    end
  end

  // Reply address: page frame from the response, offset from the member
  always_comb begin
    mask       = (PA_W'(1) << r_shift_q) - PA_W'(1);
    va_ext     = PA_W'(mem_rdata_i[VA_W-1:0]);
    reply_addr = (k_q == '0) ? r_pa_q : ((r_pa_q & ~mask) | (va_ext & mask));
  end

  // Result built in the current state
  always_comb begin
    new_res      = '0;
    new_res.id   = r_id_q;
    new_res.addr = PA_W'(r_va_q);
    new_res.wr   = r_wr_q;
    new_res.kind = KIND_REJECT;
    unique case (state_q)
      S_PR_EMIT: begin
        new_res.kind = KIND_SEND;
        new_res.id   = mem_rdata_i[MDATA_W-1:VA_W];
        new_res.addr = va_ext;
        new_res.wr   = sel_wr_q;
      end
      S_RSP_EMIT: begin
        new_res.kind = KIND_REPLY;
        new_res.id   = mem_rdata_i[MDATA_W-1:VA_W];
        new_res.addr = reply_addr;
        new_res.wr   = sel_wr_q;
        new_res.unc  = r_unc_q;
        new_res.hit  = r_hit_q;
      end
      default: ;
    endcase
  end

  // Control outputs
  always_comb begin
    accept      = in_valid_i && state_q == S_IDLE;
    in_stall_o  = state_q != S_IDLE;
    scan_end    = idx_q == GIDX_W'(NUM_GROUPS - 1);
    out_free    = !out_v_q || !out_stall_i;
    emit_go     = (state_q == S_PR_EMIT || state_q == S_RSP_EMIT) &&
                  (!hold_v_q || out_free);
    push_out    = hold_v_q && out_free &&
                  (emit_go || state_q == S_FIN);
    last_member = k_q + CNT_W'(1) == sel_cnt_q;
    div_start_o = accept && mode_i == MODE_REQ;
    mem_we_o    = state_q == S_REQ_DO && (best_v_q || slot_v_q);
    mem_waddr_o = best_v_q ? maddr(best_q, best_cnt_q) : maddr(slot_q, '0);
    mem_wdata_o = {r_id_q, r_va_q};
    mem_raddr_o = maddr(sel_q, k_q);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (mode_i)
            MODE_REQ:   state_d = S_DIV;
            MODE_PROBE: state_d = S_PR_WIN;
            MODE_RESP:  state_d = S_RSP_SCAN;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_DIV:      if (div_done_i) state_d = S_REQ_SCAN;
      S_REQ_SCAN: if (scan_end) state_d = S_REQ_DO;
      S_REQ_DO:   state_d = (best_v_q || slot_v_q) ? S_IDLE : S_FIN;
      S_PR_WIN: begin
        if (scan_end) state_d = (found_q || win_hit) ? S_PR_RANK : S_FIN;
      end
      S_PR_RANK: begin
        if (scan_end) begin
          if (found_q || rank_hit) state_d = S_PR_FLT;
          else state_d = refused_q ? S_FIN : S_PR_WIN;
        end
      end
      S_PR_FLT: begin
        if (scan_end) begin
          state_d = (busy_q || flt_hit || cred_q == '0) ? S_PR_RANK : S_PR_RD;
        end
      end
      S_PR_RD:    state_d = S_PR_EMIT;
      S_PR_EMIT: begin
        if (emit_go) state_d = (n_q + PROBE_W'(1) == limit_q) ? S_FIN : S_PR_RANK;
      end
      S_RSP_SCAN: begin
        if (scan_end) state_d = (found_q || rsp_hit) ? S_RSP_RD : S_FIN;
      end
      S_RSP_RD:   state_d = S_RSP_EMIT;
      S_RSP_EMIT: if (emit_go) state_d = last_member ? S_FIN : S_RSP_RD;
      S_FIN:      if (!hold_v_q || out_free) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // Control registers and slot status
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      status_q    <= '{default: ST_FREE};
      cnt_q       <= '{default: '0};
      hold_v_q    <= 1'b0;
      out_v_q     <= 1'b0;
      best_v_q    <= 1'b0;
      slot_v_q    <= 1'b0;
      found_q     <= 1'b0;
      busy_q      <= 1'b0;
      refused_q   <= 1'b0;
      have_prev_q <= 1'b0;
      cred_q      <= '0;
      limit_q     <= PROBE_W'(1);
      n_q         <= '0;
      r_q         <= '0;
      k_q         <= '0;
    end else begin
      state_q <= state_d;
      if (push_out) out_v_q <= 1'b1;
      else if (out_free) out_v_q <= 1'b0;
      if (accept) begin
        best_v_q    <= 1'b0;
        slot_v_q    <= 1'b0;
        found_q     <= 1'b0;
        refused_q   <= 1'b0;
        have_prev_q <= 1'b0;
        cred_q      <= down_credits_i;
        limit_q     <= lim;
        n_q         <= '0;
        k_q         <= '0;
      end
      case (state_q)
        S_REQ_SCAN: begin
          idx_q <= scan_end ? '0 : idx_q + 1'b1;
          if (join_hit) best_v_q <= 1'b1;
          if (free_hit) slot_v_q <= 1'b1;
        end
        S_REQ_DO: begin
          if (best_v_q) begin
            cnt_q[best_q] <= best_cnt_q + 1'b1;
          end else if (slot_v_q) begin
            status_q[slot_q] <= ST_WAIT;
            cnt_q[slot_q]    <= CNT_W'(1);
          end else begin
            hold_v_q <= 1'b1;
          end
        end
        S_PR_WIN: begin
          idx_q <= scan_end ? '0 : idx_q + 1'b1;
          if (win_hit) found_q <= 1'b1;
          if (scan_end) begin
            found_q <= 1'b0;
            r_q     <= '0;
          end
        end
        S_PR_RANK: begin
          idx_q <= scan_end ? '0 : idx_q + 1'b1;
          if (rank_hit) found_q <= 1'b1;
          if (scan_end) begin
            found_q <= 1'b0;
            if (!(found_q || rank_hit)) have_prev_q <= 1'b1;
          end
        end
        S_PR_FLT: begin
          idx_q <= scan_end ? '0 : idx_q + 1'b1;
          if (flt_hit) busy_q <= 1'b1;
          if (scan_end) begin
            busy_q <= 1'b0;
            if (busy_q || flt_hit || cred_q == '0) begin
              refused_q <= 1'b1;
              r_q       <= r_q + 1'b1;
            end
          end
        end
        S_PR_EMIT: begin
          if (emit_go) begin
            cred_q          <= cred_q - 1'b1;
            n_q             <= n_q + 1'b1;
            status_q[sel_q] <= ST_FLIGHT;
            hold_v_q        <= 1'b1;
          end
        end
        S_RSP_SCAN: begin
          idx_q <= scan_end ? '0 : idx_q + 1'b1;
          if (rsp_hit) found_q <= 1'b1;
          if (scan_end) found_q <= 1'b0;
        end
        S_RSP_EMIT: begin
          if (emit_go) begin
            k_q      <= k_q + 1'b1;
            hold_v_q <= 1'b1;
            if (last_member) begin
              status_q[sel_q] <= ST_FREE;
              cnt_q[sel_q]    <= '0;
            end
          end
        end
        S_FIN: begin
          if (hold_v_q && out_free) hold_v_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Payload registers and group fields
  always_ff @(posedge clk_i) begin
    if (accept) begin
      r_id_q    <= req_id_i;
      r_va_q    <= vaddr_i;
      r_wr_q    <= is_write_i;
      r_pa_q    <= resp_paddr_i;
      r_shift_q <= resp_page_shift_i;
      r_unc_q   <= resp_uncacheable_i;
      r_hit_q   <= resp_hit_level_i;
      rank_q    <= '0;
    end
    if (push_out) begin
      out_q      <= hold_q;
      out_q.last <= state_q == S_FIN;
    end
    case (state_q)
      S_REQ_SCAN: begin
        if (join_hit) begin
          best_q     <= idx_q;
          best_age_q <= e_age;
          best_cnt_q <= e_cnt;
        end
        if (free_hit) slot_q <= idx_q;
        if (rank_inc) rank_q <= rank_q + 1'b1;
      end
      S_REQ_DO: begin
        if (!best_v_q && slot_v_q) begin
          page_q[slot_q] <= r_page;
          wr_q[slot_q]   <= r_wr_q;
          win_q[slot_q]  <= div_quot_i;
          age_q[slot_q]  <= GIDX_W'(rank_q);
        end else if (!best_v_q) begin
          hold_q <= new_res;
        end
      end
      S_PR_WIN: if (win_hit) w_q <= e_win;
      S_PR_RANK: begin
        if (rank_hit) begin
          sel_q      <= idx_q;
          sel_page_q <= e_page;
          sel_wr_q   <= e_wr;
        end
        if (scan_end) prev_q <= w_q;
      end
      S_PR_EMIT: begin
        if (emit_go) begin
          hold_q <= new_res;
          // close the rank gap left by the group just sent
          for (int j = 0; j < NUM_GROUPS; j++) begin
            if (status_q[j] == ST_WAIT && win_q[j] == w_q && RANK_W'(age_q[j]) > r_q) begin
              age_q[j] <= age_q[j] - 1'b1;
            end
          end
        end
      end
      S_RSP_SCAN: begin
        if (rsp_hit) begin
          sel_q     <= idx_q;
          sel_cnt_q <= e_cnt;
          sel_wr_q  <= e_wr;
        end
      end
      S_RSP_EMIT: if (emit_go) hold_q <= new_res;
      default: ;
    endcase
  end

  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

  // Checks
  a_idle_no_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !hold_v_q) else $error("result held across items");

  a_div_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done_i |-> state_q == S_DIV) else $error("divider done outside request");

  a_probe_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PR_EMIT |-> n_q < limit_q) else $error("probe limit overrun");

  a_sent_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PR_EMIT && emit_go) |=> status_q[$past(sel_q)] == ST_FLIGHT)
    else $error("sent group not in flight");

endmodule

/* sim/tb_tlb_request_coalescer.sv */
// Self-checking testbench of the TLB request coalescer: directed table, then
// random phases under several register settings, checked against a predictor.
// Depends on tlbc_pkg and tlb_request_coalescer.
`timescale 1ns / 1ps

module tb_tlb_request_coalescer;
  import tlbc_pkg::*;

  localparam int CYCLE_LIMIT  = 2000000;
  localparam int DRAIN_CYCLES = 3000;
  localparam int HOLD_CYCLES  = 3000;
  localparam int PHASE_ITEMS  = 43;
  localparam int NUM_PHASES   = 6;
  localparam int NUM_ROWS     = 24;

  typedef struct {
    logic [1:0]         mode;
    logic [ID_W-1:0]    id;
    logic [VA_W-1:0]    va;
    logic               wr;
    logic [TIME_W-1:0]  t;
    logic [CRED_W-1:0]  cred;
    logic [PA_W-1:0]    pa;
    logic [SHIFT_W-1:0] shift;
    logic               unc;
    logic [HIT_W-1:0]   hit;
  } item_t;

  typedef struct {
    item_t stim;
    bit    typed;
    res_t  want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_idx = CFG_WINDOW;
  logic [WT_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] mode = MODE_REQ;
  logic [ID_W-1:0] req_id = '0;
  logic [VA_W-1:0] vaddr = '0;
  logic is_write = 1'b0;
  logic [TIME_W-1:0] issue_time = '0;
  logic [CRED_W-1:0] down_credits = '0;
  logic [PA_W-1:0] resp_paddr = '0;
  logic [SHIFT_W-1:0] resp_page_shift = '0;
  logic resp_uncacheable = 1'b0;
  logic [HIT_W-1:0] resp_hit_level = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] kind;
  logic [ID_W-1:0] out_id;
  logic [PA_W-1:0] out_addr;
  logic out_write, out_uncacheable, last;
  logic [HIT_W-1:0] out_hit_level;

  tlb_request_coalescer u_top (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .mode_i(mode), .req_id_i(req_id), .vaddr_i(vaddr), .is_write_i(is_write),
    .issue_time_i(issue_time), .down_credits_i(down_credits),
    .resp_paddr_i(resp_paddr), .resp_page_shift_i(resp_page_shift),
    .resp_uncacheable_i(resp_uncacheable), .resp_hit_level_i(resp_hit_level),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .kind_o(kind), .out_id_o(out_id), .out_addr_o(out_addr),
    .out_write_o(out_write), .out_uncacheable_o(out_uncacheable),
    .out_hit_level_o(out_hit_level), .last_o(last)
  );

  always #5 clk_i = ~clk_i;

  // Mirror of the group table and registers
  status_e           grp_st[NUM_GROUPS];
  logic [PAGE_W-1:0] grp_page[NUM_GROUPS];
  logic              grp_wr[NUM_GROUPS];
  logic [TIME_W-1:0] grp_win[NUM_GROUPS];
  int                grp_rank[NUM_GROUPS];
  int                grp_cnt[NUM_GROUPS];
  logic [ID_W-1:0]   mbr_tag[NUM_GROUPS*MEMBER_CAP];
  logic [VA_W-1:0]   mbr_va[NUM_GROUPS*MEMBER_CAP];
  logic [WT_W-1:0]    win_len = 1;
  logic               merge_off = 1'b0;
  logic [PROBE_W-1:0] send_limit = 1;

  res_t pending_results[$];
  int   errors = 0;
  int   cycles = 0;
  int   idle_mode = 0;
  bit   hold_req = 1'b0;
  int   hold_left = 0;

  function automatic bit opened_earlier(int a, int b);
    return grp_rank[a] < grp_rank[b] || (grp_rank[a] == grp_rank[b] && a < b);
  endfunction

  function automatic bit page_busy(logic [PAGE_W-1:0] pg);
    for (int g = 0; g < NUM_GROUPS; g++)
      if (grp_st[g] == ST_FLIGHT && grp_page[g] == pg) return 1'b1;
    return 1'b0;
  endfunction

  function automatic res_t mk_res(logic [1:0] k, logic [ID_W-1:0] id, logic [PA_W-1:0] a,
                                  logic w, logic u, logic [HIT_W-1:0] h, logic l);
    res_t r;
    r.kind = k; r.id = id; r.addr = a; r.wr = w; r.unc = u; r.hit = h; r.last = l;
    return r;
  endfunction

  // Rank waiting groups densely within each window
  task automatic rerank();
    int r[NUM_GROUPS];
    for (int g = 0; g < NUM_GROUPS; g++) begin
      r[g] = 0;
      if (grp_st[g] != ST_WAIT) continue;
      for (int h = 0; h < NUM_GROUPS; h++)
        if (h != g && grp_st[h] == ST_WAIT && grp_win[h] == grp_win[g] &&
            opened_earlier(h, g)) r[g]++;
    end
    for (int g = 0; g < NUM_GROUPS; g++)
      if (grp_st[g] == ST_WAIT) grp_rank[g] = r[g];
  endtask

  task automatic coalesce_request(item_t s);
    logic [TIME_W-1:0] win;
    logic [PAGE_W-1:0] pg;
    int best, slot, rank;
    win = s.t / TIME_W'(win_len == 0 ? 1 : win_len);
    pg = s.va[VA_W-1:PAGE_SHIFT];
    best = -1;
    slot = -1;
    rank = 0;
    if (!merge_off) begin
      for (int g = 0; g < NUM_GROUPS; g++)
        if (grp_st[g] == ST_WAIT && grp_win[g] == win && grp_page[g] == pg &&
            grp_wr[g] == s.wr && grp_cnt[g] < MEMBER_CAP &&
            (best < 0 || opened_earlier(g, best))) best = g;
      if (best >= 0) begin
        mbr_tag[best*MEMBER_CAP + grp_cnt[best]] = s.id;
        mbr_va[best*MEMBER_CAP + grp_cnt[best]] = s.va;
        grp_cnt[best]++;
        return;
      end
    end
    for (int g = 0; g < NUM_GROUPS; g++) begin
      if (grp_st[g] == ST_FREE && slot < 0) slot = g;
      if (grp_st[g] == ST_WAIT && grp_win[g] == win) rank++;
    end
    if (slot < 0) begin
      pending_results.push_back(mk_res(KIND_REJECT, s.id, PA_W'(s.va), s.wr, 0, 0, 1));
      return;
    end
    grp_st[slot] = ST_WAIT;
    grp_page[slot] = pg;
    grp_wr[slot] = s.wr;
    grp_win[slot] = win;
    grp_rank[slot] = rank;
    grp_cnt[slot] = 1;
    mbr_tag[slot*MEMBER_CAP] = s.id;
    mbr_va[slot*MEMBER_CAP] = s.va;
  endtask

  // Send waiting groups, oldest window first, stop after a refused window
  task automatic dispatch_groups(item_t s);
    int credits, lim, n, len, g, j;
    int ord[NUM_GROUPS];
    logic [TIME_W-1:0] prev, w;
    bit have_prev, refused, found, done;
    credits = s.cred;
    lim = (send_limit == 0) ? 1 : send_limit;
    if (lim > PROBE_CAP) lim = PROBE_CAP;
    n = 0; prev = '0; w = '0;
    have_prev = 0; refused = 0; done = 0;
    while (!refused && !done) begin
      found = 0;
      for (g = 0; g < NUM_GROUPS; g++)
        if (grp_st[g] == ST_WAIT && (!have_prev || grp_win[g] > prev) &&
            (!found || grp_win[g] < w)) begin
          w = grp_win[g];
          found = 1;
        end
      if (!found) break;
      len = 0;
      for (g = 0; g < NUM_GROUPS; g++)
        if (grp_st[g] == ST_WAIT && grp_win[g] == w) begin
          for (j = len; j > 0 && opened_earlier(g, ord[j-1]); j--) ord[j] = ord[j-1];
          ord[j] = g;
          len++;
        end
      for (int i = 0; i < len; i++) begin
        g = ord[i];
        if (page_busy(grp_page[g]) || credits == 0) begin
          refused = 1;
          continue;
        end
        credits--;
        grp_st[g] = ST_FLIGHT;
        pending_results.push_back(mk_res(KIND_SEND, mbr_tag[g*MEMBER_CAP],
                                         PA_W'(mbr_va[g*MEMBER_CAP]), grp_wr[g], 0, 0, 0));
        n++;
        if (n == lim) begin
          done = 1;
          break;
        end
      end
      prev = w;
      have_prev = 1;
    end
    rerank();
    if (n > 0) pending_results[pending_results.size()-1].last = 1'b1;
  endtask

  // Fan out one reply per member of the in-flight group for the page
  task automatic fan_out_replies(item_t s);
    logic [PAGE_W-1:0] pg;
    logic [63:0] mask, a;
    int g;
    pg = s.va[VA_W-1:PAGE_SHIFT];
    mask = (64'd1 << s.shift) - 64'd1;
    for (g = 0; g < NUM_GROUPS; g++)
      if (grp_st[g] == ST_FLIGHT && grp_page[g] == pg) break;
    if (g >= NUM_GROUPS) return;
    for (int k = 0; k < grp_cnt[g]; k++) begin
      a = k ? ((64'(s.pa) & ~mask) | (64'(mbr_va[g*MEMBER_CAP+k]) & mask)) : 64'(s.pa);
      pending_results.push_back(mk_res(KIND_REPLY, mbr_tag[g*MEMBER_CAP+k], a[PA_W-1:0],
                                       grp_wr[g], s.unc, s.hit, k == grp_cnt[g]-1));
    end
    grp_st[g] = ST_FREE;
    grp_cnt[g] = 0;
  endtask

  task automatic predict(item_t s);
    case (s.mode)
      MODE_REQ:   coalesce_request(s);
      MODE_PROBE: dispatch_groups(s);
      MODE_RESP:  fan_out_replies(s);
      default: ;
    endcase
  endtask

  // Offer one item and wait for it to be taken, then predict its results
  task automatic offer(item_t s);
    @(negedge clk_i);
    in_valid <= 1'b1;
    mode <= s.mode; req_id <= s.id; vaddr <= s.va; is_write <= s.wr;
    issue_time <= s.t; down_credits <= s.cred; resp_paddr <= s.pa;
    resp_page_shift <= s.shift; resp_uncacheable <= s.unc; resp_hit_level <= s.hit;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    predict(s);
  endtask

  task automatic sender_gap();
    int pct;
    int n;
    pct = (idle_mode == 1) ? 56 : (idle_mode == 3) ? 35 : 0;
    if ($urandom_range(0, 99) < pct) begin
      n = $urandom_range(1, 4);
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [WT_W-1:0] val);
    @(negedge clk_i);
    cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_WINDOW:   win_len = val;
      CFG_COALESCE: merge_off = val[0];
      CFG_PROBES:   send_limit = val[PROBE_W-1:0];
      default: ;
    endcase
  endtask

  // Wait until every expected result is in, then let the block settle
  task automatic drain();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic item_t mk(logic [1:0] md, logic [ID_W-1:0] id, logic [VA_W-1:0] va,
                               logic wr, logic [TIME_W-1:0] t, logic [CRED_W-1:0] cr,
                               logic [PA_W-1:0] pa, logic [SHIFT_W-1:0] sh, logic u,
                               logic [HIT_W-1:0] h);
    item_t s;
    s.mode = md; s.id = id; s.va = va; s.wr = wr; s.t = t; s.cred = cr;
    s.pa = pa; s.shift = sh; s.unc = u; s.hit = h;
    return s;
  endfunction

  // Random item: requests, mostly on a few hot pages, probes, responses mostly
  // aimed at pages in flight, and now and then an unused mode
  function automatic item_t rand_item(logic [PAGE_W-1:0] hot[6], logic [TIME_W-1:0] tbase);
    item_t s;
    int sel, wt;
    logic [PAGE_W-1:0] busy[$];
    s = mk(MODE_REQ, $urandom, {$urandom, $urandom}, $urandom, {$urandom, $urandom},
           $urandom_range(0, 8), {$urandom, $urandom}, $urandom_range(12, 30),
           $urandom, $urandom);
    sel = $urandom_range(0, 99);
    wt = (win_len == 0) ? 1 : win_len;
    if (sel < 50) begin
      if ($urandom_range(0, 9) != 0)
        s.va = {hot[$urandom_range(0, 5)], 12'($urandom)};
      if ($urandom_range(0, 9) != 0)
        s.t = tbase + TIME_W'($urandom_range(0, 3 * wt));
      s.wr = ($urandom_range(0, 3) == 0);
    end else if (sel < 75) begin
      s.mode = MODE_PROBE;
      if ($urandom_range(0, 9) == 0) s.cred = $urandom_range(9, 15);
    end else if (sel < 96) begin
      s.mode = MODE_RESP;
      for (int g = 0; g < NUM_GROUPS; g++)
        if (grp_st[g] == ST_FLIGHT) busy.push_back(grp_page[g]);
      if (busy.size() != 0 && $urandom_range(0, 4) != 0)
        s.va = {busy[$urandom_range(0, busy.size() - 1)], 12'($urandom)};
      if ($urandom_range(0, 3) == 0) s.shift = $urandom_range(0, 31);
    end else begin
      s.mode = 2'd3;
    end
    return s;
  endfunction

  // Receiver: random stalls, and a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (idle_mode == 2) begin
      out_stall <= ($urandom_range(0, 99) < 56);
    end else if (idle_mode == 3) begin
      out_stall <= ($urandom_range(0, 99) < 35);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Compare every taken result with the oldest expectation
  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: kind %0d id %0h addr %0h", $time, kind, out_id,
                 out_addr);
        errors++;
      end else begin
        e = pending_results.pop_front();
        check_field("kind", e.kind, kind);
        check_field("out_id", e.id, out_id);
        check_field("out_addr", e.addr, out_addr);
        check_field("out_write", e.wr, out_write);
        check_field("out_uncacheable", e.unc, out_uncacheable);
        check_field("out_hit_level", e.hit, out_hit_level);
        check_field("last", e.last, last);
      end
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  row_t rows[NUM_ROWS];

  initial begin
    logic [PAGE_W-1:0] hot[6];
    logic [TIME_W-1:0] tbase;
    int n0;
    logic [WT_W-1:0] win_set[NUM_PHASES] = '{0, 65535, 7, 100, 3, 1};
    logic            off_set[NUM_PHASES] = '{0, 0, 1, 0, 0, 1};
    logic [PROBE_W-1:0] lim_set[NUM_PHASES] = '{8, 15, 3, 0, 8, 2};

    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_st[g] = ST_FREE; grp_cnt[g] = 0; grp_rank[g] = 0;
      grp_page[g] = '0; grp_wr[g] = 0; grp_win[g] = '0;
    end

    // Directed table: unused mode, stray response, empty probe, fill the
    // table, merge, reject on full, send, refuse, reply fan-out
    foreach (rows[i]) rows[i].typed = 0;
    rows[0].stim = mk(2'd3, '1, '1, 1, '1, '1, '1, '1, 1, '1);
    rows[1].stim = mk(MODE_RESP, 8'h11, 48'h1234_5678_9000, 0, 0, 0, '1, 12, 1, 2);
    rows[2].stim = mk(MODE_PROBE, 0, 0, 0, 0, 8, 0, 12, 0, 0);
    for (int i = 0; i < 16; i++)
      rows[3+i].stim = mk(MODE_REQ, ID_W'(i), (i == 15) ? '1 : VA_W'((i << 12) | i * 5),
                          i % 2, (i == 15) ? '1 : TIME_W'(i), 0, 0, 12, 0, 0);
    rows[19].stim = mk(MODE_REQ, 8'd100, 48'h0000_0000_0ABC, 0, 0, 0, 0, 12, 0, 0);
    rows[20].stim = mk(MODE_REQ, 8'hFF, '1, 0, '1, 0, 0, 12, 0, 0);
    rows[20].typed = 1;
    rows[20].want = mk_res(KIND_REJECT, 8'hFF, PA_W'({VA_W{1'b1}}), 0, 0, 0, 1);
    rows[21].stim = mk(MODE_PROBE, 0, 0, 0, 0, 8, 0, 12, 0, 0);
    rows[22].stim = mk(MODE_PROBE, 0, 0, 0, 0, 0, 0, 12, 0, 0);
    rows[23].stim = mk(MODE_RESP, 0, 48'h0000_0000_0FFF, 0, 0, 0, '1, 31, 1, 3);

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) begin
      n0 = pending_results.size();
      offer(rows[i].stim);
      if (rows[i].typed) begin
        while (pending_results.size() > n0) void'(pending_results.pop_back());
        pending_results.push_back(rows[i].want);
      end
    end
    drain();

    // Random phases, each under its own register setting and idling
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(CFG_WINDOW, win_set[p]);
      write_reg(CFG_COALESCE, WT_W'(off_set[p]));
      write_reg(CFG_PROBES, WT_W'(lim_set[p]));
      idle_mode = p % 4;
      foreach (hot[k]) hot[k] = PAGE_W'({$urandom, $urandom});
      tbase = TIME_W'({$urandom, $urandom}) >> 1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 1 && i == 5) hold_req = 1'b1;
        offer(rand_item(hot, tbase));
        sender_gap();
      end
      drain();
    end

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
